/* hdl/nnrm_pkg.sv */
// nnrm_pkg: shared constants, codes and control types for the nearest node radius match unit
// no dependencies; used by nnrm_ctrl, nnrm_dp and nearest_node_radius_match_unit
`timescale 1ns / 1ps
`default_nettype none

package nnrm_pkg;

  // table size and number format
  localparam int MAX_NODES = 1024;
  localparam int FRAC_BITS = 4;

  localparam int COORD_W = 20;
  localparam int RAD_W = 16;
  localparam int MODE_W = 2;
  localparam int STATUS_W = 3;
  localparam int OUT_IDX_W = 10;

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int CNT_W = IDX_W + 1;

  // node entry: {radius, z, y, x}
  localparam int NODE_W = 3 * COORD_W + RAD_W;

  // distance arithmetic
  localparam int DIFF_W = COORD_W + 1;
  localparam int SQ_W = 2 * DIFF_W;
  localparam int D2_W = SQ_W + 2;
  localparam int RSQ_W = 2 * RAD_W;

  // search limit of 1.0e4 units, squared, with 2*FRAC_BITS fraction bits
  localparam logic [D2_W-1:0] LIMIT_SQ = D2_W'(64'd100000000 << (2 * FRAC_BITS));

  // stream widths; mode and status travel on tuser
  localparam int IN_TDATA_W = ((3 * COORD_W + RAD_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((OUT_IDX_W + 7) / 8) * 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD   = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_MATCH   = 3'd0,
    STAT_NOMATCH = 3'd1,
    STAT_STORED  = 3'd2,
    STAT_FULL    = 3'd3,
    STAT_CLEARED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_MISC,
    S_SCAN,
    S_DRAIN,
    S_RADSQ,
    S_DECIDE,
    S_DONE
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic take_in;
    logic do_add;
    logic do_misc;
    logic scan_step;
    logic rad_sq;
    logic decide;
    logic load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic pipe_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

/* hdl/nearest_node_radius_match_unit.sv */
// result path: add, clear and unused-mode beats pass through the add or misc state, then done;
// a query passes through scan, drain, radius square, decide and done
// throughput: one beat in flight at a time; a query is bound by the single table read
// port, one stored node per cycle, plus a drain of the distance pipeline
// reset: node count cleared, output empty; table contents are not cleared
// (entries at or above the node count are never read)
`timescale 1ns / 1ps
`default_nettype none

module nearest_node_radius_match_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input stream
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [nnrm_pkg::IN_TDATA_W-1:0]     in_tdata,   // x, y, z, radius, zero pad
  input  wire logic [nnrm_pkg::MODE_W-1:0]         in_tuser,   // mode
  // result stream
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [nnrm_pkg::OUT_TDATA_W-1:0]         out_tdata,  // match_index, zero pad
  output logic [nnrm_pkg::STATUS_W-1:0]            out_tuser   // status
);

  localparam int CW = nnrm_pkg::COORD_W;
  localparam int MW = nnrm_pkg::MODE_W;
  localparam int RAD_LO = 3 * CW;
  localparam int IN_USED = RAD_LO + nnrm_pkg::RAD_W;
  localparam int OUT_USED = nnrm_pkg::OUT_IDX_W;

  nnrm_pkg::dp_cmd_t   cmd;
  nnrm_pkg::dp_stat_t  stat;

  // unpacked input beat fields
  logic [MW-1:0]                   in_mode;
  logic signed [CW-1:0]            in_x, in_y, in_z;
  logic [nnrm_pkg::RAD_W-1:0]      in_radius;

  nnrm_pkg::status_t               res_status;
  logic [nnrm_pkg::OUT_IDX_W-1:0]  res_index;

  assign in_mode   = in_tuser;
  assign in_x      = in_tdata[CW-1:0];
  assign in_y      = in_tdata[2*CW-1:CW];
  assign in_z      = in_tdata[3*CW-1:2*CW];
  assign in_radius = in_tdata[IN_USED-1:RAD_LO];

  // sequencing: idle, add or misc, or scan/drain/radius square/decide, then output
  nnrm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_mode   (in_mode),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // table, distance pipeline and result registers
  nnrm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_mode    (in_mode),
    .in_x       (in_x),
    .in_y       (in_y),
    .in_z       (in_z),
    .in_radius  (in_radius),
    .out_status (res_status),
    .out_index  (res_index)
  );

  // pack the result beat: index in tdata, status on tuser
  assign out_tdata = {{(nnrm_pkg::OUT_TDATA_W - OUT_USED){1'b0}}, res_index};
  assign out_tuser = res_status;

endmodule

`default_nettype wire

/* hdl/nnrm_ctrl.sv */
// nnrm_ctrl: sequencing state machine for add, clear, unused-mode and query items
// depends on nnrm_pkg; drives nnrm_dp through dp_cmd_t and reads dp_stat_t
`timescale 1ns / 1ps
`default_nettype none

module nnrm_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic [nnrm_pkg::MODE_W-1:0]   in_mode,
  output logic                               in_ready,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  input  wire nnrm_pkg::dp_stat_t            stat,
  output nnrm_pkg::dp_cmd_t                  cmd
);

  nnrm_pkg::ctrl_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;
  logic out_free;

  assign accept   = in_valid && (state_r == nnrm_pkg::S_IDLE);
  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nnrm_pkg::S_IDLE: begin
        if (accept) begin
          case (nnrm_pkg::mode_t'(in_mode))
            nnrm_pkg::MODE_ADD:   state_nxt = nnrm_pkg::S_ADD;
            nnrm_pkg::MODE_QUERY: state_nxt = nnrm_pkg::S_SCAN;
            default:              state_nxt = nnrm_pkg::S_MISC;
          endcase
        end
      end
      nnrm_pkg::S_ADD:    state_nxt = nnrm_pkg::S_DONE;
      nnrm_pkg::S_MISC:   state_nxt = nnrm_pkg::S_DONE;
      nnrm_pkg::S_SCAN: begin
        if (stat.scan_done) state_nxt = nnrm_pkg::S_DRAIN;
      end
      nnrm_pkg::S_DRAIN: begin
        if (!stat.pipe_busy) state_nxt = nnrm_pkg::S_RADSQ;
      end
      nnrm_pkg::S_RADSQ:  state_nxt = nnrm_pkg::S_DECIDE;
      nnrm_pkg::S_DECIDE: state_nxt = nnrm_pkg::S_DONE;
      nnrm_pkg::S_DONE: begin
        if (out_free) state_nxt = nnrm_pkg::S_IDLE;
      end
      default:            state_nxt = nnrm_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    case (state_r)
      nnrm_pkg::S_IDLE:   cmd.take_in   = accept;
      nnrm_pkg::S_ADD:    cmd.do_add    = 1'b1;
      nnrm_pkg::S_MISC:   cmd.do_misc   = 1'b1;
      nnrm_pkg::S_SCAN:   cmd.scan_step = !stat.scan_done;
      nnrm_pkg::S_RADSQ:  cmd.rad_sq    = 1'b1;
      nnrm_pkg::S_DECIDE: cmd.decide    = 1'b1;
      nnrm_pkg::S_DONE:   cmd.load_out  = out_free;
      default:            cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nnrm_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == nnrm_pkg::S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* hdl/nnrm_dp.sv */
// nnrm_dp: node table memory, node count, distance pipeline, best tracker and result registers
// depends on nnrm_pkg; commanded by nnrm_ctrl
`timescale 1ns / 1ps
`default_nettype none

module nnrm_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire nnrm_pkg::dp_cmd_t                    cmd,
  output nnrm_pkg::dp_stat_t                        stat,
  input  wire logic [nnrm_pkg::MODE_W-1:0]          in_mode,
  input  wire logic signed [nnrm_pkg::COORD_W-1:0]  in_x,
  input  wire logic signed [nnrm_pkg::COORD_W-1:0]  in_y,
  input  wire logic signed [nnrm_pkg::COORD_W-1:0]  in_z,
  input  wire logic [nnrm_pkg::RAD_W-1:0]           in_radius,
  output nnrm_pkg::status_t                         out_status,
  output logic [nnrm_pkg::OUT_IDX_W-1:0]            out_index
);

  localparam int CW = nnrm_pkg::COORD_W;

  // latched item
  logic [nnrm_pkg::MODE_W-1:0]   mode_r;
  logic signed [CW-1:0]          qx_r, qy_r, qz_r;
  logic [nnrm_pkg::RAD_W-1:0]    qr_r;

  // table
  logic [nnrm_pkg::NODE_W-1:0]   node_mem [nnrm_pkg::MAX_NODES];
  logic [nnrm_pkg::NODE_W-1:0]   rd_data_r;
  logic [nnrm_pkg::CNT_W-1:0]    count_r;
  logic                          full;

  // scan pipeline
  logic [nnrm_pkg::CNT_W-1:0]    addr_r;
  logic                          v1_r, v2_r, v3_r, v4_r;
  logic [nnrm_pkg::IDX_W-1:0]    idx1_r, idx2_r, idx3_r, idx4_r;
  logic [nnrm_pkg::RAD_W-1:0]    rad2_r, rad3_r, rad4_r;
  logic [nnrm_pkg::DIFF_W-1:0]   adx_r, ady_r, adz_r;
  logic [nnrm_pkg::SQ_W-1:0]     sqx_r, sqy_r, sqz_r;
  logic [nnrm_pkg::D2_W-1:0]     sum4_r;

  // best candidate
  logic [nnrm_pkg::D2_W-1:0]     best_d2_r;
  logic [nnrm_pkg::IDX_W-1:0]    best_idx_r;
  logic [nnrm_pkg::RAD_W-1:0]    best_rad_r;
  logic                          found_r;
  logic [nnrm_pkg::RSQ_W-1:0]    rq_r, rn_r;
  logic                          match;

  // result and output registers
  nnrm_pkg::status_t             res_status_r;
  logic [nnrm_pkg::OUT_IDX_W-1:0] res_index_r;
  nnrm_pkg::status_t             out_status_r;
  logic [nnrm_pkg::OUT_IDX_W-1:0] out_index_r;

  // memory fields of the registered read word
  logic signed [CW-1:0]          mx, my, mz;
  logic [nnrm_pkg::RAD_W-1:0]    mr;
  // signed differences need one bit above the magnitude width
  logic signed [nnrm_pkg::DIFF_W:0] dx, dy, dz;

  assign full = (count_r == nnrm_pkg::CNT_W'(nnrm_pkg::MAX_NODES));

  assign mx = rd_data_r[CW-1:0];
  assign my = rd_data_r[2*CW-1:CW];
  assign mz = rd_data_r[3*CW-1:2*CW];
  assign mr = rd_data_r[nnrm_pkg::NODE_W-1:3*CW];

  assign dx = {{2{qx_r[CW-1]}}, qx_r} - {{2{mx[CW-1]}}, mx};
  assign dy = {{2{qy_r[CW-1]}}, qy_r} - {{2{my[CW-1]}}, my};
  assign dz = {{2{qz_r[CW-1]}}, qz_r} - {{2{mz[CW-1]}}, mz};

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      mode_r <= in_mode;
      qx_r   <= in_x;
      qy_r   <= in_y;
      qz_r   <= in_z;
      qr_r   <= in_radius;
    end
  end

  // table write and registered read
  always_ff @(posedge clk) begin
    if (cmd.do_add && !full) begin
      node_mem[count_r[nnrm_pkg::IDX_W-1:0]] <= {qr_r, qz_r, qy_r, qx_r};
    end
    if (cmd.scan_step) begin
      rd_data_r <= node_mem[addr_r[nnrm_pkg::IDX_W-1:0]];
    end
  end

  // node count and scan address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      addr_r  <= '0;
    end else begin
      if (cmd.do_add && !full) begin
        count_r <= count_r + 1'b1;
      end else if (cmd.do_misc && (mode_r == nnrm_pkg::MODE_CLEAR)) begin
        count_r <= '0;
      end
      if (cmd.take_in) begin
        addr_r <= '0;
      end else if (cmd.scan_step) begin
        addr_r <= addr_r + 1'b1;
      end
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= cmd.scan_step;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // distance stages: abs diff, squares, sum
  always_ff @(posedge clk) begin
    idx1_r <= addr_r[nnrm_pkg::IDX_W-1:0];
    idx2_r <= idx1_r;
    idx3_r <= idx2_r;
    idx4_r <= idx3_r;
    rad2_r <= mr;
    rad3_r <= rad2_r;
    rad4_r <= rad3_r;
    adx_r  <= dx[nnrm_pkg::DIFF_W] ? nnrm_pkg::DIFF_W'(-dx) : nnrm_pkg::DIFF_W'(dx);
    ady_r  <= dy[nnrm_pkg::DIFF_W] ? nnrm_pkg::DIFF_W'(-dy) : nnrm_pkg::DIFF_W'(dy);
    adz_r  <= dz[nnrm_pkg::DIFF_W] ? nnrm_pkg::DIFF_W'(-dz) : nnrm_pkg::DIFF_W'(dz);
    sqx_r  <= nnrm_pkg::SQ_W'(adx_r) * nnrm_pkg::SQ_W'(adx_r);
    sqy_r  <= nnrm_pkg::SQ_W'(ady_r) * nnrm_pkg::SQ_W'(ady_r);
    sqz_r  <= nnrm_pkg::SQ_W'(adz_r) * nnrm_pkg::SQ_W'(adz_r);
    sum4_r <= nnrm_pkg::D2_W'(sqx_r) + nnrm_pkg::D2_W'(sqy_r) + nnrm_pkg::D2_W'(sqz_r);
  end

  // best tracker: strict less-than keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.take_in) begin
      found_r <= 1'b0;
    end else if (v4_r && (sum4_r < best_d2_r)) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      best_d2_r <= nnrm_pkg::LIMIT_SQ;
    end else if (v4_r && (sum4_r < best_d2_r)) begin
      best_d2_r  <= sum4_r;
      best_idx_r <= idx4_r;
      best_rad_r <= rad4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rad_sq) begin
      rq_r <= nnrm_pkg::RSQ_W'(qr_r) * nnrm_pkg::RSQ_W'(qr_r);
      rn_r <= nnrm_pkg::RSQ_W'(best_rad_r) * nnrm_pkg::RSQ_W'(best_rad_r);
    end
  end

  assign match = found_r && ((nnrm_pkg::D2_W'(rq_r) > best_d2_r) ||
                             (nnrm_pkg::D2_W'(rn_r) > best_d2_r));

  // result of the current item
  always_ff @(posedge clk) begin
    if (cmd.do_add) begin
      res_status_r <= full ? nnrm_pkg::STAT_FULL : nnrm_pkg::STAT_STORED;
      res_index_r  <= full ? '0 : nnrm_pkg::OUT_IDX_W'(count_r);
    end else if (cmd.do_misc) begin
      res_status_r <= (mode_r == nnrm_pkg::MODE_CLEAR) ? nnrm_pkg::STAT_CLEARED
                                                       : nnrm_pkg::STAT_NOMATCH;
      res_index_r  <= '0;
    end else if (cmd.decide) begin
      res_status_r <= match ? nnrm_pkg::STAT_MATCH : nnrm_pkg::STAT_NOMATCH;
      res_index_r  <= match ? nnrm_pkg::OUT_IDX_W'(best_idx_r) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_index_r  <= res_index_r;
    end
  end

  assign out_status     = out_status_r;
  assign out_index      = out_index_r;
  assign stat.scan_done = (addr_r >= count_r);
  assign stat.pipe_busy = v1_r || v2_r || v3_r || v4_r;

endmodule

`default_nettype wire
